@@ design/assert_macros.svh @@
// concurrent assertion helpers, empty for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RHC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHC_ASSERT(lbl, prop, msg)
`define RHC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ design/rhc_pkg.sv @@
package rhc_pkg;

  localparam int COMPONENT_BITS_DEF = 8;
  localparam int HUE_FRAC_BITS_DEF  = 4;

  localparam int HUE_BITS = 13;
  localparam int SAT_BITS = 8;
  localparam int VAL_BITS = 8;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

endpackage

@@ design/rgb_to_hsv_converter_unit.sv @@
// throughput: one pixel per cycle while out_ready is high, one restoring divider bit per pipeline stage
// the chain of stage registers advances on a ready chain, bubbles are squeezed out
// reset: synchronous, clears every stage valid bit, payload registers are not reset
module rgb_to_hsv_converter_unit #(
  parameter int COMPONENT_BITS = rhc_pkg::COMPONENT_BITS_DEF,
  parameter int HUE_FRAC_BITS  = rhc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COMPONENT_BITS-1:0]     red,
  input  logic [COMPONENT_BITS-1:0]     green,
  input  logic [COMPONENT_BITS-1:0]     blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rhc_pkg::HUE_BITS-1:0]  hue,
  output logic [rhc_pkg::SAT_BITS-1:0]  saturation,
  output logic [rhc_pkg::VAL_BITS-1:0]  brightness
);
  import rhc_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int QB = $clog2((60 << HUE_FRAC_BITS) + 1);
  localparam int D  = (QB > CB) ? QB : CB;
  localparam int NH = CB + QB;
  localparam int NS = 2 * CB;

  logic          valid  [D+1];
  logic          ready  [D+1];
  logic [NH-1:0] rem_h  [D+1];
  logic [QB-1:0] q_h    [D+1];
  logic [NS-1:0] rem_s  [D+1];
  logic [CB-1:0] q_s    [D+1];
  logic [CB-1:0] chroma [D+1];
  logic [CB-1:0] hi     [D+1];
  sector_t       sector [D+1];
  logic          neg    [D+1];

  rhc_front #(
    .CB(CB),
    .HF(HUE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .dn_valid  (valid[0]),
    .dn_ready  (ready[0]),
    .dn_num_h  (rem_h[0]),
    .dn_num_s  (rem_s[0]),
    .dn_chroma (chroma[0]),
    .dn_hi     (hi[0]),
    .dn_sector (sector[0]),
    .dn_neg    (neg[0])
  );

  assign q_h[0] = '0;
  assign q_s[0] = '0;

  for (genvar k = 0; k < D; k++) begin : g_stage
    rhc_div_stage #(
      .CB(CB),
      .QB(QB),
      .J (D - 1 - k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (valid[k]),
      .up_ready  (ready[k]),
      .up_rem_h  (rem_h[k]),
      .up_q_h    (q_h[k]),
      .up_rem_s  (rem_s[k]),
      .up_q_s    (q_s[k]),
      .up_chroma (chroma[k]),
      .up_hi     (hi[k]),
      .up_sector (sector[k]),
      .up_neg    (neg[k]),
      .dn_valid  (valid[k+1]),
      .dn_ready  (ready[k+1]),
      .dn_rem_h  (rem_h[k+1]),
      .dn_q_h    (q_h[k+1]),
      .dn_rem_s  (rem_s[k+1]),
      .dn_q_s    (q_s[k+1]),
      .dn_chroma (chroma[k+1]),
      .dn_hi     (hi[k+1]),
      .dn_sector (sector[k+1]),
      .dn_neg    (neg[k+1])
    );
  end

  rhc_back #(
    .CB(CB),
    .HF(HUE_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (valid[D]),
    .up_ready   (ready[D]),
    .up_rem_h   (rem_h[D]),
    .up_q_h     (q_h[D]),
    .up_q_s     (q_s[D]),
    .up_chroma  (chroma[D]),
    .up_hi      (hi[D]),
    .up_sector  (sector[D]),
    .up_neg     (neg[D]),
    .dn_valid   (out_valid),
    .dn_ready   (out_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule

@@ design/rhc_front.sv @@
module rhc_front #(
  parameter int CB = rhc_pkg::COMPONENT_BITS_DEF,
  parameter int HF = rhc_pkg::HUE_FRAC_BITS_DEF,
  localparam int QB = $clog2((60 << HF) + 1),
  localparam int NH = CB + QB,
  localparam int NS = 2 * CB
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [CB-1:0]        red,
  input  logic [CB-1:0]        green,
  input  logic [CB-1:0]        blue,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [NH-1:0]        dn_num_h,
  output logic [NS-1:0]        dn_num_s,
  output logic [CB-1:0]        dn_chroma,
  output logic [CB-1:0]        dn_hi,
  output rhc_pkg::sector_t     dn_sector,
  output logic                 dn_neg
);
  import rhc_pkg::*;

  localparam logic [NH-1:0] SIXTY = NH'(60 << HF);
  localparam logic [NS-1:0] MAXC  = NS'((1 << CB) - 1);

  logic [CB-1:0] hi_c, lo_c, pa, pb, dmag_c;
  sector_t       sec_c;
  logic          neg_c;

  logic          valid_a, ready_a;
  logic [CB-1:0] hi_a, chroma_a, dmag_a;
  sector_t       sector_a;
  logic          neg_a;

  logic          valid_b, ready_b;
  logic [NH-1:0] num_h_b;
  logic [NS-1:0] num_s_b;
  logic [CB-1:0] chroma_b, hi_b;
  sector_t       sector_b;
  logic          neg_b;

  // largest and smallest, earlier component wins a tie
  always_comb begin
    hi_c  = red;
    lo_c  = red;
    sec_c = SECTOR_RED;
    if (green > hi_c) begin
      hi_c  = green;
      sec_c = SECTOR_GREEN;
    end
    if (green < lo_c) lo_c = green;
    if (blue > hi_c) begin
      hi_c  = blue;
      sec_c = SECTOR_BLUE;
    end
    if (blue < lo_c) lo_c = blue;
    unique case (sec_c)
      SECTOR_RED: begin
        pa = green;
        pb = blue;
      end
      SECTOR_GREEN: begin
        pa = blue;
        pb = red;
      end
      SECTOR_BLUE: begin
        pa = red;
        pb = green;
      end
      default: begin
        pa = '0;
        pb = '0;
      end
    endcase
    neg_c  = pa < pb;
    dmag_c = neg_c ? pb - pa : pa - pb;
  end

  assign ready_a  = !valid_a || ready_b;
  assign ready_b  = !valid_b || dn_ready;
  assign up_ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ready_a) begin
      valid_a <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      hi_a     <= hi_c;
      chroma_a <= hi_c - lo_c;
      dmag_a   <= dmag_c;
      sector_a <= sec_c;
      neg_a    <= neg_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (ready_b) begin
      valid_b <= valid_a;
    end
  end

  // constant scalings for both numerators
  always_ff @(posedge clk) begin
    if (ready_b) begin
      num_h_b  <= SIXTY * NH'(dmag_a);
      num_s_b  <= MAXC * NS'(chroma_a);
      chroma_b <= chroma_a;
      hi_b     <= hi_a;
      sector_b <= sector_a;
      neg_b    <= neg_a;
    end
  end

  assign dn_valid  = valid_b;
  assign dn_num_h  = num_h_b;
  assign dn_num_s  = num_s_b;
  assign dn_chroma = chroma_b;
  assign dn_hi     = hi_b;
  assign dn_sector = sector_b;
  assign dn_neg    = neg_b;

endmodule

@@ design/rhc_div_stage.sv @@
`include "assert_macros.svh"

module rhc_div_stage #(
  parameter int CB = rhc_pkg::COMPONENT_BITS_DEF,
  parameter int QB = 10,
  parameter int J  = 0,
  localparam int NH = CB + QB,
  localparam int NS = 2 * CB
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [NH-1:0]    up_rem_h,
  input  logic [QB-1:0]    up_q_h,
  input  logic [NS-1:0]    up_rem_s,
  input  logic [CB-1:0]    up_q_s,
  input  logic [CB-1:0]    up_chroma,
  input  logic [CB-1:0]    up_hi,
  input  rhc_pkg::sector_t up_sector,
  input  logic             up_neg,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [NH-1:0]    dn_rem_h,
  output logic [QB-1:0]    dn_q_h,
  output logic [NS-1:0]    dn_rem_s,
  output logic [CB-1:0]    dn_q_s,
  output logic [CB-1:0]    dn_chroma,
  output logic [CB-1:0]    dn_hi,
  output rhc_pkg::sector_t dn_sector,
  output logic             dn_neg
);
  import rhc_pkg::*;

  localparam int WH = (CB + J > NH) ? CB + J : NH;
  localparam int WS = (CB + J > NS) ? CB + J : NS;

  logic [NH-1:0] rem_h_next;
  logic [QB-1:0] q_h_next;
  logic [NS-1:0] rem_s_next;
  logic [CB-1:0] q_s_next;

  logic          valid;
  logic [NH-1:0] rem_h;
  logic [QB-1:0] q_h;
  logic [NS-1:0] rem_s;
  logic [CB-1:0] q_s;
  logic [CB-1:0] chroma;
  logic [CB-1:0] hi;
  sector_t       sector;
  logic          neg;

  logic [WH-1:0] bound_h;
  logic [WS-1:0] bound_s;

  // hue quotient bit
  if (J < QB) begin : g_hue
    logic [WH-1:0] dh, rh;
    always_comb begin
      dh = WH'(up_chroma) << J;
      rh = WH'(up_rem_h);
      if (rh >= dh) begin
        rem_h_next = NH'(rh - dh);
        q_h_next   = up_q_h | (QB'(1) << J);
      end else begin
        rem_h_next = up_rem_h;
        q_h_next   = up_q_h;
      end
    end
  end else begin : g_hue_pass
    assign rem_h_next = up_rem_h;
    assign q_h_next   = up_q_h;
  end

  // saturation quotient bit
  if (J < CB) begin : g_sat
    logic [WS-1:0] ds, rs;
    always_comb begin
      ds = WS'(up_hi) << J;
      rs = WS'(up_rem_s);
      if (rs >= ds) begin
        rem_s_next = NS'(rs - ds);
        q_s_next   = up_q_s | (CB'(1) << J);
      end else begin
        rem_s_next = up_rem_s;
        q_s_next   = up_q_s;
      end
    end
  end else begin : g_sat_pass
    assign rem_s_next = up_rem_s;
    assign q_s_next   = up_q_s;
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      rem_h  <= rem_h_next;
      q_h    <= q_h_next;
      rem_s  <= rem_s_next;
      q_s    <= q_s_next;
      chroma <= up_chroma;
      hi     <= up_hi;
      sector <= up_sector;
      neg    <= up_neg;
    end
  end

  assign dn_valid  = valid;
  assign dn_rem_h  = rem_h;
  assign dn_q_h    = q_h;
  assign dn_rem_s  = rem_s;
  assign dn_q_s    = q_s;
  assign dn_chroma = chroma;
  assign dn_hi     = hi;
  assign dn_sector = sector;
  assign dn_neg    = neg;

  // partial remainder stays below the divisor at this bit weight
  assign bound_h = WH'(chroma) << J;
  assign bound_s = WS'(hi) << J;

  `RHC_ASSERT(a_rem_h_bound, valid && chroma != '0 |-> WH'(rem_h) < bound_h, "hue rem range")
  `RHC_ASSERT(a_rem_s_bound, valid && hi != '0 |-> WS'(rem_s) < bound_s, "sat rem range")
  `RHC_ASSERT(a_stall_hold, valid && !dn_ready |=> valid && $stable(rem_h) && $stable(q_s), "stall")

endmodule

@@ design/rhc_back.sv @@
`include "assert_macros.svh"

module rhc_back #(
  parameter int CB = rhc_pkg::COMPONENT_BITS_DEF,
  parameter int HF = rhc_pkg::HUE_FRAC_BITS_DEF,
  localparam int QB = $clog2((60 << HF) + 1),
  localparam int NH = CB + QB
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [NH-1:0]                 up_rem_h,
  input  logic [QB-1:0]                 up_q_h,
  input  logic [CB-1:0]                 up_q_s,
  input  logic [CB-1:0]                 up_chroma,
  input  logic [CB-1:0]                 up_hi,
  input  rhc_pkg::sector_t              up_sector,
  input  logic                          up_neg,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [rhc_pkg::HUE_BITS-1:0]  hue,
  output logic [rhc_pkg::SAT_BITS-1:0]  saturation,
  output logic [rhc_pkg::VAL_BITS-1:0]  brightness
);
  import rhc_pkg::*;

  localparam int SIXTY = 60 << HF;
  localparam int FULL  = 6 * SIXTY;
  localparam int HW    = $clog2(FULL + 1);
  localparam int HOW   = (HW > HUE_BITS) ? HW : HUE_BITS;
  localparam int SOW   = (CB > SAT_BITS) ? CB : SAT_BITS;
  localparam int VOW   = (CB > VAL_BITS) ? CB : VAL_BITS;

  logic [QB-1:0]  mag;
  logic [HW-1:0]  base, hue_v;
  logic [CB-1:0]  sat_v;
  logic [HOW-1:0] hue_w;
  logic [SOW-1:0] sat_w;
  logic [VOW-1:0] val_w;

  logic                valid;
  logic [HUE_BITS-1:0] hue_q;
  logic [SAT_BITS-1:0] sat_q;
  logic [VAL_BITS-1:0] val_q;

  // floor of a negative ratio rounds the magnitude up
  always_comb begin
    mag = up_q_h + QB'(up_neg && (up_rem_h != '0));
    unique case (up_sector)
      SECTOR_RED:   base = up_neg ? HW'(FULL) : '0;
      SECTOR_GREEN: base = HW'(2 * SIXTY);
      SECTOR_BLUE:  base = HW'(4 * SIXTY);
      default:      base = '0;
    endcase
    if (up_chroma == '0) begin
      hue_v = '0;
    end else if (up_neg) begin
      hue_v = base - HW'(mag);
    end else begin
      hue_v = base + HW'(mag);
    end
    sat_v = (up_hi == '0) ? '0 : up_q_s;
    hue_w = HOW'(hue_v);
    sat_w = SOW'(sat_v);
    val_w = VOW'(up_hi);
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      hue_q <= hue_w[HUE_BITS-1:0];
      sat_q <= sat_w[SAT_BITS-1:0];
      val_q <= val_w[VAL_BITS-1:0];
    end
  end

  assign dn_valid   = valid;
  assign hue        = hue_q;
  assign saturation = sat_q;
  assign brightness = val_q;

  `RHC_ASSERT_RST(a_rst_clear, rst |=> !valid, "output valid after reset")
  `RHC_ASSERT(a_hue_range, up_valid && up_chroma != '0 |-> hue_v < HW'(FULL), "hue range")
  `RHC_ASSERT(a_black, up_valid && up_hi == '0 |-> hue_v == '0 && sat_v == '0, "black pixel")
  `RHC_ASSERT(a_sector, up_valid && up_chroma != '0 && up_sector != SECTOR_RED |-> hue_v >= HW'(SIXTY), "sector")

endmodule
